// ----- src/srs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg: shared definitions for the sorted range search block
// Widths, codes, reset values and control structs used across the block.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int unsigned DEPTH_DEF = 1024;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned TOL_W     = 31;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned IDX_OUT_W = 10;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned BOUND_W   = 34;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd32768;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_QUERY  = 2'd2,
    FN_NOP    = 2'd3
  } func_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2,
    ST_ORDER    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LB_RD,
    S_LB_CMP,
    S_UB_RD,
    S_UB_CMP,
    S_FIN
  } state_e;

  // Control of the shared window comparator.
  typedef struct packed {
    logic load;   // capture new window bounds from target and tolerance
    logic upper;  // compare against the upper bound instead of the lower one
  } win_ctrl_t;

endpackage

// ----- src/srs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_if: handshake channels of the sorted range search block
// Input item, result item and tolerance write channels with valid/ready.
// ----------------------------------------------------------------------------
interface srs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [srs_pkg::FUNC_W-1:0]    func;
  logic signed [srs_pkg::VAL_W-1:0]     value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface srs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [srs_pkg::ST_W-1:0]      status;
  logic        [srs_pkg::IDX_OUT_W-1:0] first_index;
  logic        [srs_pkg::CNT_OUT_W-1:0] match_count;
  logic        [srs_pkg::CNT_OUT_W-1:0] stored_count;

  modport source (output valid, output status, output first_index, output match_count,
                  output stored_count, input ready);
  modport sink   (input valid, input status, input first_index, input match_count,
                  input stored_count, output ready);
endinterface

interface srs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic        [srs_pkg::TOL_W-1:0]     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/srs_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_window: window bounds and shared element comparator
// Holds the lower bound and one past the upper bound of the query window and
// tells whether an element lies at or above the selected bound.
// ----------------------------------------------------------------------------
module srs_window (
  input  logic                              clk_i,
  input  srs_pkg::win_ctrl_t                ctrl_i,
  input  logic signed [srs_pkg::VAL_W-1:0]  target_i,
  input  logic        [srs_pkg::TOL_W-1:0]  tol_i,
  input  logic signed [srs_pkg::VAL_W-1:0]  elem_i,
  output logic                              ge_o
);

  logic signed [srs_pkg::BOUND_W-1:0] target_ext;
  logic signed [srs_pkg::BOUND_W-1:0] tol_ext;
  logic signed [srs_pkg::BOUND_W-1:0] elem_ext;
  logic signed [srs_pkg::BOUND_W-1:0] lo_q;
  logic signed [srs_pkg::BOUND_W-1:0] hi1_q;

  assign target_ext = {{(srs_pkg::BOUND_W - srs_pkg::VAL_W){target_i[srs_pkg::VAL_W-1]}},
                       target_i};
  assign tol_ext    = {{(srs_pkg::BOUND_W - srs_pkg::TOL_W){1'b0}}, tol_i};
  assign elem_ext   = {{(srs_pkg::BOUND_W - srs_pkg::VAL_W){elem_i[srs_pkg::VAL_W-1]}},
                       elem_i};

  // The upper search looks for the first element above target + tolerance,
  // which is the first element at or above that bound plus one.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      lo_q  <= target_ext - tol_ext;
      hi1_q <= target_ext + tol_ext + srs_pkg::BOUND_W'(1);
    end
  end

  assign ge_o = elem_ext >= (ctrl_i.upper ? hi1_q : lo_q);

endmodule

// ----- src/sorted_range_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_search: ascending Q16.16 store with windowed range query
// A clear empties the store, an append adds a value at the end, and a query
// returns the first index and the count of elements within target +/- tolerance.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item per transaction: func (clear, append, query) and a
//   signed Q16.16 value. out_o returns exactly one result transaction per
//   item: status, first_index, match_count and stored_count. cfg_i writes the
//   31-bit tolerance and is always ready; write it only while the block idles.
//   Clear, append and the unused code pass through the EXEC and FIN states;
//   the next item can be accepted in the cycle its result is offered.
//   A query runs two binary searches (lower bound of the window, then first
//   element above it) on one memory read port. Each probe passes a read state
//   and a compare state, and a search ends in a read state that finds its
//   interval empty, with up to floor(log2(m)) + 1 probes over m entries. The
//   result is offered after the FIN state, and the next item can be accepted
//   as soon as it is offered. in_i.ready is high only while idle.
//   The result sits in an output register, so a new item is accepted while the
//   previous result waits; if the receiver stalls, the next item finishes and
//   holds in its final state until the output register frees up.
//   Reset empties the store and sets tolerance to 0.5. The element memory
//   itself is not cleared; only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module sorted_range_search #(
  parameter int unsigned DEPTH = srs_pkg::DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srs_in_if.sink    in_i,
  srs_out_if.source out_o,
  srs_cfg_if.sink   cfg_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  srs_pkg::state_e state_q, state_d;

  logic [srs_pkg::TOL_W-1:0]       tol_q;
  logic [CW-1:0]                   n_q;
  logic [srs_pkg::FUNC_W-1:0]      func_q;
  logic signed [srs_pkg::VAL_W-1:0] value_q;
  logic signed [srs_pkg::VAL_W-1:0] last_q;
  logic signed [srs_pkg::VAL_W-1:0] rd_data_q;
  logic [CW-1:0]                   left_q;
  logic [CW-1:0]                   right_q;
  logic [CW-1:0]                   mid_q;
  logic [CW-1:0]                   first_q;
  logic [CW-1:0]                   mid;
  logic [CW-1:0]                   span;
  logic [CW-1:0]                   count;

  srs_pkg::status_e                res_status_q;
  logic [CW-1:0]                   res_first_q;
  logic [CW-1:0]                   res_count_q;

  logic                            out_valid_q;
  logic [srs_pkg::ST_W-1:0]        out_status_q;
  logic [srs_pkg::IDX_OUT_W-1:0]   out_first_q;
  logic [srs_pkg::CNT_OUT_W-1:0]   out_match_q;
  logic [srs_pkg::CNT_OUT_W-1:0]   out_stored_q;

  logic signed [srs_pkg::VAL_W-1:0] store_mem [DEPTH];

  logic                            in_ready;
  logic                            searching;
  logic                            rd_en;
  logic                            wr_en;
  logic                            load_out;
  logic                            full;
  logic                            order_bad;
  logic                            ge;
  srs_pkg::win_ctrl_t              win_ctrl;
  srs_pkg::func_e                  func;

  assign func      = srs_pkg::func_e'(func_q);
  assign span      = right_q - left_q;
  assign mid       = left_q + (span >> 1);
  assign count     = left_q - first_q;
  assign searching = left_q < right_q;
  assign full      = n_q >= CW'(DEPTH);
  assign order_bad = (n_q != '0) && (value_q < last_q);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srs_pkg::S_IDLE: begin
        if (in_i.valid) state_d = srs_pkg::S_EXEC;
      end
      srs_pkg::S_EXEC: begin
        state_d = (func == srs_pkg::FN_QUERY) ? srs_pkg::S_LB_RD : srs_pkg::S_FIN;
      end
      srs_pkg::S_LB_RD: begin
        state_d = searching ? srs_pkg::S_LB_CMP : srs_pkg::S_UB_RD;
      end
      srs_pkg::S_LB_CMP: begin
        state_d = srs_pkg::S_LB_RD;
      end
      srs_pkg::S_UB_RD: begin
        state_d = searching ? srs_pkg::S_UB_CMP : srs_pkg::S_FIN;
      end
      srs_pkg::S_UB_CMP: begin
        state_d = srs_pkg::S_UB_RD;
      end
      srs_pkg::S_FIN: begin
        if (load_out) state_d = srs_pkg::S_IDLE;
      end
      default: state_d = srs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_q == srs_pkg::S_IDLE);
    rd_en          = ((state_q == srs_pkg::S_LB_RD) || (state_q == srs_pkg::S_UB_RD)) &&
                     searching;
    wr_en          = (state_q == srs_pkg::S_EXEC) && (func == srs_pkg::FN_APPEND) &&
                     !full && !order_bad;
    win_ctrl.load  = (state_q == srs_pkg::S_EXEC);
    win_ctrl.upper = (state_q == srs_pkg::S_UB_RD) || (state_q == srs_pkg::S_UB_CMP);
    load_out       = (state_q == srs_pkg::S_FIN) && (!out_valid_q || out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srs_pkg::S_IDLE;
      tol_q       <= srs_pkg::TOL_RESET;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) tol_q <= cfg_i.data;
      if ((state_q == srs_pkg::S_EXEC) && (func == srs_pkg::FN_CLEAR)) begin
        n_q <= '0;
      end else if (wr_en) begin
        n_q <= n_q + CW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      func_q  <= in_i.func;
      value_q <= in_i.value;
    end

    unique case (state_q)
      srs_pkg::S_EXEC: begin
        res_status_q <= srs_pkg::ST_OK;
        res_first_q  <= '0;
        res_count_q  <= '0;
        left_q       <= '0;
        right_q      <= n_q;
        if (func == srs_pkg::FN_APPEND) begin
          if (full) begin
            res_status_q <= srs_pkg::ST_FULL;
          end else if (order_bad) begin
            res_status_q <= srs_pkg::ST_ORDER;
          end else begin
            last_q <= value_q;
          end
        end
      end
      srs_pkg::S_LB_RD: begin
        mid_q <= mid;
        if (!searching) begin
          // Lower bound found; the upper search runs over the rest of the store.
          first_q <= left_q;
          right_q <= n_q;
        end
      end
      srs_pkg::S_UB_RD: begin
        mid_q <= mid;
        if (!searching) begin
          if (count == '0) begin
            res_status_q <= srs_pkg::ST_NO_MATCH;
            res_first_q  <= '0;
            res_count_q  <= '0;
          end else begin
            res_status_q <= srs_pkg::ST_OK;
            res_first_q  <= first_q;
            res_count_q  <= count;
          end
        end
      end
      srs_pkg::S_LB_CMP, srs_pkg::S_UB_CMP: begin
        if (ge) begin
          right_q <= mid_q;
        end else begin
          left_q <= mid_q + CW'(1);
        end
      end
      srs_pkg::S_IDLE, srs_pkg::S_FIN: begin
      end
      default: begin
      end
    endcase

    if (load_out) begin
      out_status_q <= res_status_q;
      out_first_q  <= srs_pkg::IDX_OUT_W'(res_first_q);
      out_match_q  <= srs_pkg::CNT_OUT_W'(res_count_q);
      out_stored_q <= srs_pkg::CNT_OUT_W'(n_q);
    end
  end

  // Element memory: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[n_q[IW-1:0]] <= value_q;
    if (rd_en) rd_data_q <= store_mem[mid[IW-1:0]];
  end

  srs_window u_window (
    .clk_i    (clk_i),
    .ctrl_i   (win_ctrl),
    .target_i (value_q),
    .tol_i    (tol_q),
    .elem_i   (rd_data_q),
    .ge_o     (ge)
  );

  assign in_i.ready         = in_ready;
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.first_index  = out_first_q;
  assign out_o.match_count  = out_match_q;
  assign out_o.stored_count = out_stored_q;

endmodule

// ----- src/srs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_checker: port-level checks for the sorted range search block
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module srs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [srs_pkg::ST_W-1:0]       status_i,
  input logic [srs_pkg::IDX_OUT_W-1:0]  first_index_i,
  input logic [srs_pkg::CNT_OUT_W-1:0]  match_count_i
);

  // A result transaction stays offered until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // Items are processed one at a time, so acceptance closes the input.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is in progress");

  // An empty window reports no range.
  a_no_match_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == srs_pkg::ST_NO_MATCH) |->
      (first_index_i == '0) && (match_count_i == '0))
    else $error("no-match result carries a range");

  // Rejected appends never report a range.
  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((status_i == srs_pkg::ST_FULL) || (status_i == srs_pkg::ST_ORDER)) |->
      (first_index_i == '0) && (match_count_i == '0))
    else $error("rejected append carries a range");

endmodule

bind sorted_range_search srs_checker u_srs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .first_index_i (out_o.first_index),
  .match_count_i (out_o.match_count)
);
